// ----- design/rgbtb_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbtb_pkg
// Shared types and constants of the 3x3 trimmed-mean RGB blur.
// ----------------------------------------------------------------------------
package rgbtb_pkg;

   // register file
   localparam int FRAME_WIDTH_W  = 11;
   localparam int FRAME_HEIGHT_W = 12;
   localparam int CSR_DATA_W     = 12;

   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

   // smallest frame side that has an interior
   localparam int MIN_DIM = 3;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // result positions
   localparam int ROW_W     = 12;
   localparam int OUT_COL_W = 10;

   // divide by 7 as multiply by ceil(2^15/7), exact below 5461
   localparam int          DIV7_SHIFT = 15;
   localparam logic [12:0] DIV7_MUL   = 13'd4682;
   localparam int          TRIM_W     = 11;
   localparam int          CHAN_MAX   = 255;

   // result queue
   localparam int RSP_DEPTH = 16;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pix_type;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [7:0]           out_red;
      logic [7:0]           out_green;
      logic [7:0]           out_blue;
      logic [ROW_W-1:0]     out_row;
      logic [OUT_COL_W-1:0] out_col;
      logic                 is_border;
      logic                 frame_done;
   } rsp_type;

endpackage

// ----- design/rgbtb_trim.sv -----
// ----------------------------------------------------------------------------
// rgbtb_trim
// Trimmed mean of a 3x3 window: sum of nine pixels per channel minus the
// darkest (last on ties) and brightest (first on ties) pixel, divided by 7.
// Two register stages; the quotient is formed from the second stage.
// ----------------------------------------------------------------------------
module rgbtb_trim (
   input  logic                       clock,
   input  rgbtb_pkg::pix_type [8:0]   win,
   output rgbtb_pkg::pix_type         mean
);

   typedef struct packed {
      logic [9:0]         lum;
      rgbtb_pkg::pix_type px;
   } node_type;

   // later operand wins ties for the minimum
   function automatic node_type lo_pick(input node_type a, input node_type b);
      return (b.lum <= a.lum) ? b : a;
   endfunction

   // earlier operand wins ties for the maximum
   function automatic node_type hi_pick(input node_type a, input node_type b);
      return (b.lum > a.lum) ? b : a;
   endfunction

   node_type [8:0]            node1_ff;
   logic [2:0][11:0]          sum1_in;
   logic [2:0][11:0]          sum1_ff;
   node_type [8:0]            node1_in;
   node_type [3:0]            lo_a, hi_a;
   node_type [1:0]            lo_b, hi_b;
   node_type                  lo_c, hi_c, lo_d, hi_d;
   logic [2:0][rgbtb_pkg::TRIM_W-1:0] trim2_in;
   logic [2:0][rgbtb_pkg::TRIM_W-1:0] trim2_ff;
   logic [2:0][23:0]          prod;
   logic [2:0][8:0]           quot;
   logic [2:0][7:0]           chan_out;

   // stage 1: intensities and channel sums
   always_comb begin
      sum1_in = '0;
      for (int k = 0; k < 9; k++) begin
         node1_in[k].px  = win[k];
         node1_in[k].lum = 10'(win[k].red) + 10'(win[k].green) + 10'(win[k].blue);
         sum1_in[0] = sum1_in[0] + 12'(win[k].red);
         sum1_in[1] = sum1_in[1] + 12'(win[k].green);
         sum1_in[2] = sum1_in[2] + 12'(win[k].blue);
      end
   end

   always_ff @(posedge clock) begin
      node1_ff <= node1_in;
      sum1_ff  <= sum1_in;
   end

   // stage 2: order-keeping min/max tree, then trim the two extremes
   always_comb begin
      for (int p = 0; p < 4; p++) begin
         lo_a[p] = lo_pick(node1_ff[2*p], node1_ff[2*p+1]);
         hi_a[p] = hi_pick(node1_ff[2*p], node1_ff[2*p+1]);
      end
      for (int p = 0; p < 2; p++) begin
         lo_b[p] = lo_pick(lo_a[2*p], lo_a[2*p+1]);
         hi_b[p] = hi_pick(hi_a[2*p], hi_a[2*p+1]);
      end
      lo_c = lo_pick(lo_b[0], lo_b[1]);
      hi_c = hi_pick(hi_b[0], hi_b[1]);
      lo_d = lo_pick(lo_c, node1_ff[8]);
      hi_d = hi_pick(hi_c, node1_ff[8]);
      trim2_in[0] = rgbtb_pkg::TRIM_W'(sum1_ff[0] - 12'(lo_d.px.red)   - 12'(hi_d.px.red));
      trim2_in[1] = rgbtb_pkg::TRIM_W'(sum1_ff[1] - 12'(lo_d.px.green) - 12'(hi_d.px.green));
      trim2_in[2] = rgbtb_pkg::TRIM_W'(sum1_ff[2] - 12'(lo_d.px.blue)  - 12'(hi_d.px.blue));
   end

   always_ff @(posedge clock) begin
      trim2_ff <= trim2_in;
   end

   // divide by 7 and clamp
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch] = 24'(trim2_ff[ch]) * 24'(rgbtb_pkg::DIV7_MUL);
         quot[ch] = prod[ch][rgbtb_pkg::DIV7_SHIFT +: 9];
         chan_out[ch] = (quot[ch] > 9'(rgbtb_pkg::CHAN_MAX)) ?
                        8'(rgbtb_pkg::CHAN_MAX) : quot[ch][7:0];
      end
      mean.red   = chan_out[0];
      mean.green = chan_out[1];
      mean.blue  = chan_out[2];
   end

endmodule

// ----- design/rgbtb_rsp_fifo.sv -----
// ----------------------------------------------------------------------------
// rgbtb_rsp_fifo
// Result queue: takes up to two results per clock (a filtered pixel and a
// border copy, in that order) and hands out one per transfer.
// ----------------------------------------------------------------------------
module rgbtb_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_a_en,
   input  rgbtb_pkg::rsp_type push_a,
   input  logic               push_b_en,
   input  rgbtb_pkg::rsp_type push_b,
   input  logic               pop,
   output logic               not_empty,
   output rgbtb_pkg::rsp_type head
);

   localparam int AW = $clog2(rgbtb_pkg::RSP_DEPTH);

   rgbtb_pkg::rsp_type store_ff [rgbtb_pkg::RSP_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;
   logic [AW-1:0] wr_b_ptr;

   // pointer and fill bookkeeping
   always_comb begin
      wr_b_ptr  = push_a_en ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      wr_ptr_in = wr_ptr_ff + AW'(push_a_en) + AW'(push_b_en);
      rd_ptr_in = rd_ptr_ff + AW'(pop);
      count_in  = count_ff + (AW+1)'(push_a_en) + (AW+1)'(push_b_en) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_a_en) begin
         store_ff[wr_ptr_ff] <= push_a;
      end
      if (push_b_en) begin
         store_ff[wr_b_ptr] <= push_b;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = store_ff[rd_ptr_ff];

endmodule

// ----- design/rgb_3x3_trimmed_blur_core.sv -----
// ----------------------------------------------------------------------------
// rgb_3x3_trimmed_blur_core
// 3x3 trimmed-mean blur on an RGB raster stream with border pass-through.
// ----------------------------------------------------------------------------
// The core takes one raster pixel per clock while the result side takes one
// result per clock, except in the last row of a frame. Each pixel reads its
// column of a MAX_WIDTH x 48-bit line memory (the two rows above) in the
// accept cycle and writes the column back in the next cycle, so the memory's
// single read and single write port set the one-pixel-per-clock figure.
// A filtered pixel goes from the input that completes its window through the
// first control register, the window register and the trim stages into the
// result queue and can be taken on the following clock; a border copy travels
// with the input that carries it. In the middle rows interior columns give
// one result, the second column none and the last column two, so results go
// through a 16-entry queue; req_ready falls when the results already owed
// reach 15. In the last row every pixel from the third column on owes two
// results, so even with rsp_ready held high the queue soon fills there and
// the input then takes a pixel only as results leave, until the row ends; a
// receiver that holds rsp_ready low stalls the input the same way. Results
// carry their row and column and are not in raster order. A write to either
// frame register restarts the frame at row 0, column 0; write them only while
// no pixel is in flight. The line memory has no clearing pass: within a frame
// every entry is written before any filtered result uses it.
// ----------------------------------------------------------------------------
module rgb_3x3_trimmed_blur_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  rgbtb_pkg::req_type              req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output rgbtb_pkg::rsp_type              rsp_data,
   input  logic                            csr_we,
   input  rgbtb_pkg::csr_index_type        csr_index,
   input  logic [rgbtb_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > rgbtb_pkg::FRAME_WIDTH_W) ?
                           $clog2(MAX_WIDTH + 1) : rgbtb_pkg::FRAME_WIDTH_W;
   localparam int CRED_W = $clog2(rgbtb_pkg::RSP_DEPTH + 1);
   localparam int ROW_W  = rgbtb_pkg::ROW_W;
   localparam int OCW    = rgbtb_pkg::OUT_COL_W;

   typedef struct packed {
      rgbtb_pkg::pix_type top;
      rgbtb_pkg::pix_type mid;
   } line_word_type;

   typedef struct packed {
      logic               filt;
      logic               copy;
      logic               done;
      logic [ROW_W-1:0]   row;
      logic [OCW-1:0]     col;
      rgbtb_pkg::pix_type px;
   } ctl_type;

   // frame registers and raster counters
   logic [rgbtb_pkg::FRAME_WIDTH_W-1:0]  width_ff;
   logic [rgbtb_pkg::FRAME_HEIGHT_W-1:0] height_ff;
   logic [CW-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [WCMP_W-1:0]  width_ext, width_eff, width_last;
   logic [CW-1:0]      last_col;
   logic [ROW_W-1:0]   height_eff, last_row;

   // pipeline
   logic               accept;
   ctl_type            ctl_acc;
   logic [3:0]         vld_ff;
   ctl_type            ctl_ff [4];
   logic [CW-1:0]      addr1_ff;
   line_word_type      line_mem [MAX_WIDTH];
   line_word_type      rd_word_ff;
   rgbtb_pkg::pix_type [8:0] win_ff;
   rgbtb_pkg::pix_type mean;

   // result side
   logic [CRED_W-1:0]  credit_ff, credit_in;
   logic               pop;
   logic               push_a_en, push_b_en;
   rgbtb_pkg::rsp_type push_a, push_b;

   // effective frame size, clamped
   always_comb begin
      width_ext = WCMP_W'(width_ff);
      if (width_ext < WCMP_W'(rgbtb_pkg::MIN_DIM)) begin
         width_eff = WCMP_W'(rgbtb_pkg::MIN_DIM);
      end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
         width_eff = WCMP_W'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      width_last = width_eff - WCMP_W'(1);
      last_col   = width_last[CW-1:0];
      height_eff = (height_ff < ROW_W'(rgbtb_pkg::MIN_DIM)) ?
                   ROW_W'(rgbtb_pkg::MIN_DIM) : height_ff;
      last_row   = height_eff - ROW_W'(1);
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rgbtb_pkg::FRAME_WIDTH_RESET;
         height_ff <= rgbtb_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rgbtb_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[rgbtb_pkg::FRAME_WIDTH_W-1:0];
            rgbtb_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input transfer and per-pixel result plan
   assign req_ready = (credit_ff <= CRED_W'(rgbtb_pkg::RSP_DEPTH - 2));
   assign accept    = req_valid & req_ready;

   always_comb begin
      ctl_acc.px.red   = req_data.in_red;
      ctl_acc.px.green = req_data.in_green;
      ctl_acc.px.blue  = req_data.in_blue;
      ctl_acc.row      = row_ff;
      ctl_acc.col      = OCW'(col_ff);
      ctl_acc.filt     = (row_ff >= ROW_W'(2)) && (col_ff >= CW'(2));
      ctl_acc.copy     = (row_ff == '0) || (col_ff == '0) ||
                         (row_ff >= last_row) || (col_ff >= last_col);
      ctl_acc.done     = (row_ff >= last_row) && (col_ff >= last_col);
   end

   // raster position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ff >= last_col) begin
            col_in = '0;
            row_in = (row_ff >= last_row) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // control pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff[0] <= ctl_acc;
      ctl_ff[1] <= ctl_ff[0];
      ctl_ff[2] <= ctl_ff[1];
      ctl_ff[3] <= ctl_ff[2];
      addr1_ff  <= col_ff;
   end

   // line memory: read the column at accept, write it back in the next cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_word_ff <= line_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (vld_ff[0]) begin
         line_mem[addr1_ff] <= '{top: rd_word_ff.mid, mid: ctl_ff[0].px};
      end
   end

   // window shift, newest column on the right
   always_ff @(posedge clock) begin
      if (vld_ff[0]) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[3*i]   <= win_ff[3*i+1];
            win_ff[3*i+1] <= win_ff[3*i+2];
         end
         win_ff[2] <= rd_word_ff.top;
         win_ff[5] <= rd_word_ff.mid;
         win_ff[8] <= ctl_ff[0].px;
      end
   end

   rgbtb_trim u_trim (
      .clock (clock),
      .win   (win_ff),
      .mean  (mean)
   );

   // results into the queue: filtered pixel first, then the border copy
   always_comb begin
      push_a_en         = vld_ff[3] & ctl_ff[3].filt;
      push_a.out_red    = mean.red;
      push_a.out_green  = mean.green;
      push_a.out_blue   = mean.blue;
      push_a.out_row    = ctl_ff[3].row - ROW_W'(1);
      push_a.out_col    = ctl_ff[3].col - OCW'(1);
      push_a.is_border  = 1'b0;
      push_a.frame_done = 1'b0;

      push_b_en         = vld_ff[3] & ctl_ff[3].copy;
      push_b.out_red    = ctl_ff[3].px.red;
      push_b.out_green  = ctl_ff[3].px.green;
      push_b.out_blue   = ctl_ff[3].px.blue;
      push_b.out_row    = ctl_ff[3].row;
      push_b.out_col    = ctl_ff[3].col;
      push_b.is_border  = 1'b1;
      push_b.frame_done = ctl_ff[3].done;
   end

   rgbtb_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_a_en (push_a_en),
      .push_a    (push_a),
      .push_b_en (push_b_en),
      .push_b    (push_b),
      .pop       (pop),
      .not_empty (rsp_valid),
      .head      (rsp_data)
   );

   assign pop = rsp_valid & rsp_ready;

   // results owed: reserved at input transfer, released at output transfer
   always_comb begin
      credit_in = credit_ff - CRED_W'(pop);
      if (accept) begin
         credit_in = credit_in + CRED_W'(ctl_acc.filt) + CRED_W'(ctl_acc.copy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

endmodule

// ----- design/rgbtb_sva.sv -----
// ----------------------------------------------------------------------------
// rgbtb_sva
// Port-level checks of the trimmed-mean blur core, bound to the top level.
// ----------------------------------------------------------------------------
module rgbtb_sva (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input rgbtb_pkg::req_type               req_data,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input rgbtb_pkg::rsp_type               rsp_data,
   input logic                             csr_we,
   input rgbtb_pkg::csr_index_type         csr_index,
   input logic [rgbtb_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // queue comes out of reset empty
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // end of frame is always flagged on a border copy
   a_done_on_border: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_done |-> rsp_data.is_border)
      else $error("frame_done on a filtered pixel");

   // a filtered pixel never sits in the top row
   a_filtered_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_border |-> rsp_data.out_row != '0)
      else $error("filtered pixel reported in row 0");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

endmodule

bind rgb_3x3_trimmed_blur_core rgbtb_sva u_rgbtb_sva (.*);

// ----- sim/tb_rgb_3x3_trimmed_blur_core.sv -----
// ----------------------------------------------------------------------------
// tb_rgb_3x3_trimmed_blur_core
// Self-checking bench for the 3x3 trimmed-mean RGB blur core.
// ----------------------------------------------------------------------------
// Pixels are streamed in raster order over the request channel. Frame sizes
// come from the csr port. Every accepted pixel is run through a cycle-free
// model of the window, the line buffers and the frame counters. The model
// queues the results that pixel owes, and every result transfer is checked
// in order against that queue. The run covers tie-breaking windows, frames
// back to back, restarts in the middle of a frame, clamped register values
// and the start of a frame at the widest size. It adds random small frames
// under three mixes of sender and receiver idling and one long receiver
// hold-off.
// ----------------------------------------------------------------------------
module tb_rgb_3x3_trimmed_blur_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_ROWS     = 4095;
   localparam int SETTLE_CLKS  = 20;
   localparam int HOLD_CLKS    = 150;
   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_ITEMS = 290;

   // ------------------------------------------------------------------------
   // expected-result model of the blur and its result queue
   // ------------------------------------------------------------------------
   class blur_scoreboard;
      logic [rgbtb_pkg::FRAME_WIDTH_W-1:0]  width_reg;
      logic [rgbtb_pkg::FRAME_HEIGHT_W-1:0] height_reg;
      rgbtb_pkg::pix_type line_mem [0:2*MAX_WIDTH-1];
      rgbtb_pkg::pix_type win [0:8];
      int unsigned        col;
      int unsigned        row;
      rgbtb_pkg::rsp_type owed_pixels [$];
      int unsigned        errors;

      function new();
         width_reg  = rgbtb_pkg::FRAME_WIDTH_RESET;
         height_reg = rgbtb_pkg::FRAME_HEIGHT_RESET;
         foreach (line_mem[i]) line_mem[i] = '0;
         foreach (win[i]) win[i] = '0;
         col    = 0;
         row    = 0;
         errors = 0;
      endfunction

      function int unsigned owed_count();
         return owed_pixels.size();
      endfunction

      // a write to either register restarts the frame
      function void write_reg(rgbtb_pkg::csr_index_type idx,
                              logic [rgbtb_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            rgbtb_pkg::CSR_FRAME_WIDTH:
               width_reg  = value[rgbtb_pkg::FRAME_WIDTH_W-1:0];
            rgbtb_pkg::CSR_FRAME_HEIGHT:
               height_reg = value[rgbtb_pkg::FRAME_HEIGHT_W-1:0];
            default: ;
         endcase
         col = 0;
         row = 0;
      endfunction

      // channel sums minus the darkest (last on ties) and brightest (first on ties)
      function rgbtb_pkg::pix_type trimmed_mean();
         int unsigned sum_r, sum_g, sum_b;
         int unsigned lo_v, hi_v, v;
         int unsigned t_r, t_g, t_b;
         int          lo_i, hi_i;
         rgbtb_pkg::pix_type res;
         sum_r = 0;
         sum_g = 0;
         sum_b = 0;
         lo_i  = 0;
         hi_i  = 0;
         lo_v  = 0;
         hi_v  = 0;
         for (int k = 0; k < 9; k++) begin
            v = 32'(win[k].red) + 32'(win[k].green) + 32'(win[k].blue);
            sum_r += 32'(win[k].red);
            sum_g += 32'(win[k].green);
            sum_b += 32'(win[k].blue);
            if (k == 0) begin
               lo_v = v;
               hi_v = v;
            end else if (v > hi_v) begin
               hi_v = v;
               hi_i = k;
            end else if (v <= lo_v) begin
               lo_v = v;
               lo_i = k;
            end
         end
         t_r = (sum_r - 32'(win[lo_i].red) - 32'(win[hi_i].red)) / 7;
         t_g = (sum_g - 32'(win[lo_i].green) - 32'(win[hi_i].green)) / 7;
         t_b = (sum_b - 32'(win[lo_i].blue) - 32'(win[hi_i].blue)) / 7;
         if (t_r > rgbtb_pkg::CHAN_MAX) t_r = rgbtb_pkg::CHAN_MAX;
         if (t_g > rgbtb_pkg::CHAN_MAX) t_g = rgbtb_pkg::CHAN_MAX;
         if (t_b > rgbtb_pkg::CHAN_MAX) t_b = rgbtb_pkg::CHAN_MAX;
         res.red   = t_r[7:0];
         res.green = t_g[7:0];
         res.blue  = t_b[7:0];
         return res;
      endfunction

      // accepted pixel: advance window, buffers and counters, queue what it owes
      function void note_pixel(rgbtb_pkg::req_type d);
         rgbtb_pkg::pix_type px, top, mid, filt;
         rgbtb_pkg::rsp_type item;
         int unsigned        w, h;
         bit                 last_col, last_row;
         w = 32'(width_reg);
         if (w < rgbtb_pkg::MIN_DIM) w = rgbtb_pkg::MIN_DIM;
         if (w > MAX_WIDTH) w = MAX_WIDTH;
         h = 32'(height_reg);
         if (h < rgbtb_pkg::MIN_DIM) h = rgbtb_pkg::MIN_DIM;
         if (h > MAX_ROWS) h = MAX_ROWS;
         px  = {d.in_red, d.in_green, d.in_blue};
         top = line_mem[col];
         mid = line_mem[MAX_WIDTH + col];
         for (int i = 0; i < 3; i++) begin
            win[i*3]   = win[i*3 + 1];
            win[i*3+1] = win[i*3 + 2];
         end
         win[2] = top;
         win[5] = mid;
         win[8] = px;
         line_mem[col]             = mid;
         line_mem[MAX_WIDTH + col] = px;
         last_col = (col + 1 >= w);
         last_row = (row + 1 >= h);

         // filtered pixel one row up and one column left
         if (row >= 2 && col >= 2) begin
            filt            = trimmed_mean();
            item.out_red    = filt.red;
            item.out_green  = filt.green;
            item.out_blue   = filt.blue;
            item.out_row    = rgbtb_pkg::ROW_W'(row - 1);
            item.out_col    = rgbtb_pkg::OUT_COL_W'(col - 1);
            item.is_border  = 1'b0;
            item.frame_done = 1'b0;
            owed_pixels.push_back(item);
         end

         // border copy; the frame's final pixel is always one
         if (row == 0 || col == 0 || last_row || last_col) begin
            item.out_red    = px.red;
            item.out_green  = px.green;
            item.out_blue   = px.blue;
            item.out_row    = rgbtb_pkg::ROW_W'(row);
            item.out_col    = rgbtb_pkg::OUT_COL_W'(col);
            item.is_border  = 1'b1;
            item.frame_done = last_row && last_col;
            owed_pixels.push_back(item);
         end

         if (last_col) begin
            col = 0;
            row = last_row ? 0 : row + 1;
         end else begin
            col = col + 1;
         end
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rgbtb_pkg::rsp_type got);
         rgbtb_pkg::rsp_type want;
         if (owed_pixels.size() == 0) begin
            $error("result with none owed: row %0d col %0d", got.out_row, got.out_col);
            errors++;
            return;
         end
         want = owed_pixels.pop_front();
         check_field("out_red", 32'(want.out_red), 32'(got.out_red));
         check_field("out_green", 32'(want.out_green), 32'(got.out_green));
         check_field("out_blue", 32'(want.out_blue), 32'(got.out_blue));
         check_field("out_row", 32'(want.out_row), 32'(got.out_row));
         check_field("out_col", 32'(want.out_col), 32'(got.out_col));
         check_field("is_border", 32'(want.is_border), 32'(got.is_border));
         check_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // signals and instance
   // ------------------------------------------------------------------------
   logic                             clock     = 1'b0;
   logic                             reset     = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   rgbtb_pkg::req_type               req_data  = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   rgbtb_pkg::rsp_type               rsp_data;
   logic                             csr_we    = 1'b0;
   rgbtb_pkg::csr_index_type         csr_index = rgbtb_pkg::CSR_FRAME_WIDTH;
   logic [rgbtb_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   blur_scoreboard sb = new();

   int unsigned send_idle_pct = 10;
   int unsigned recv_idle_pct = 56;
   bit          hold_rsp      = 1'b0;
   int unsigned stall_cycles  = 0;
   int unsigned random_sent   = 0;

   rgb_3x3_trimmed_blur_core #(
      .MAX_WIDTH (MAX_WIDTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // transfer monitor: feeds the model and checks results
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_pixel(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side: random backpressure, or a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CLKS) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // driver tasks
   // ------------------------------------------------------------------------
   function automatic rgbtb_pkg::req_type random_pixel();
      rgbtb_pkg::req_type p;
      int unsigned        mode;
      mode = $urandom_range(9);
      if (mode < 6) begin
         p = rgbtb_pkg::req_type'(24'($urandom));
      end else if (mode < 8) begin
         // saturated channels
         p.in_red   = $urandom_range(1) ? 8'hff : 8'h00;
         p.in_green = $urandom_range(1) ? 8'hff : 8'h00;
         p.in_blue  = $urandom_range(1) ? 8'hff : 8'h00;
      end else begin
         // narrow range, lots of intensity ties
         p.in_red   = 8'(100 + $urandom_range(1));
         p.in_green = 8'(100 + $urandom_range(1));
         p.in_blue  = 8'(100 + $urandom_range(1));
      end
      return p;
   endfunction

   // offer one pixel and hold it until the transfer
   task automatic send_pixel(input rgbtb_pkg::req_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   task automatic send_pixels(input int unsigned n);
      repeat (n) begin
         send_pixel(random_pixel());
         random_sent++;
      end
   endtask

   // wait for every owed result, then let the pipeline empty
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.owed_count() != 0) @(posedge clock);
      repeat (SETTLE_CLKS) @(posedge clock);
   endtask

   task automatic write_frame_regs(input int unsigned w, input int unsigned h);
      csr_we    <= 1'b1;
      csr_index <= rgbtb_pkg::CSR_FRAME_WIDTH;
      csr_wdata <= rgbtb_pkg::CSR_DATA_W'(w);
      @(posedge clock);
      sb.write_reg(rgbtb_pkg::CSR_FRAME_WIDTH, rgbtb_pkg::CSR_DATA_W'(w));
      csr_index <= rgbtb_pkg::CSR_FRAME_HEIGHT;
      csr_wdata <= rgbtb_pkg::CSR_DATA_W'(h);
      @(posedge clock);
      sb.write_reg(rgbtb_pkg::CSR_FRAME_HEIGHT, rgbtb_pkg::CSR_DATA_W'(h));
      csr_we <= 1'b0;
   endtask

   task automatic run_segment(input int unsigned w, input int unsigned h,
                              input int unsigned n);
      drain();
      write_frame_regs(w, h);
      send_pixels(n);
   endtask

   task automatic run_small_frame();
      int unsigned w, h, n;
      w = $urandom_range(rgbtb_pkg::MIN_DIM, 9);
      h = $urandom_range(rgbtb_pkg::MIN_DIM, 6);
      n = w * h * $urandom_range(1, 2);
      // now and then a frame cut short by a restart
      if ($urandom_range(4) == 0) n = $urandom_range(1, w * h - 1);
      run_segment(w, h, n);
   endtask

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      rgbtb_pkg::req_type tie_px [0:8];
      tie_px[0] = '{8'd255, 8'd0, 8'd0};
      tie_px[1] = '{8'd0, 8'd255, 8'd0};
      tie_px[2] = '{8'd0, 8'd0, 8'd255};
      tie_px[3] = '{8'd100, 8'd100, 8'd55};
      tie_px[4] = '{8'd0, 8'd128, 8'd127};
      tie_px[5] = '{8'd85, 8'd85, 8'd85};
      tie_px[6] = '{8'd255, 8'd0, 8'd0};
      tie_px[7] = '{8'd1, 8'd254, 8'd0};
      tie_px[8] = '{8'd0, 8'd0, 8'd255};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // smallest frame, every window pixel of equal intensity
      write_frame_regs(rgbtb_pkg::MIN_DIM, rgbtb_pkg::MIN_DIM);
      for (int i = 0; i < 9; i++) send_pixel(tie_px[i]);
      // next frame right behind: full-scale pixels around a black center
      for (int i = 0; i < 9; i++) begin
         if (i == 4) send_pixel('{8'd0, 8'd0, 8'd0});
         else send_pixel('{8'd255, 8'd255, 8'd255});
      end
      // partial frame, restarted by the next register write
      repeat (4) send_pixel('{8'd0, 8'd0, 8'd0});

      // sender idles lightly, receiver heavily
      run_segment(5, 4, 20);
      run_segment(0, 0, 18);               // both clamp up to 3
      run_segment(4, MAX_ROWS, 16);        // tallest frame, started only
      run_segment(2, 7, 21);
      run_small_frame();

      // sender idles heavily, receiver lightly
      send_idle_pct = 56;
      recv_idle_pct = 10;
      run_segment(6, 5, $urandom_range(8, 25));
      run_small_frame();

      // long receiver hold-off while pixels keep coming
      drain();
      write_frame_regs(8, 6);
      send_idle_pct = 0;
      hold_rsp      = 1'b1;
      send_pixels(48);
      send_idle_pct = 56;
      run_small_frame();

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_segment(MAX_WIDTH, MAX_ROWS, 10);
      run_segment(12'h7ff, rgbtb_pkg::MIN_DIM, 24);   // clamps to full width, first row only
      while (random_sent < RANDOM_ITEMS) run_small_frame();

      drain();
      if (sb.errors == 0 && sb.owed_count() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/rgbtb_pkg.sv
design/rgbtb_trim.sv
design/rgbtb_rsp_fifo.sv
design/rgb_3x3_trimmed_blur_core.sv
design/rgbtb_sva.sv
sim/tb_rgb_3x3_trimmed_blur_core.sv
